>>> design/olia_pkg.sv
// ----------------------------------------------------------------------------
// olia_pkg
// shared constants, types and the alpha magnitude table for the olia alpha
// calculator
// ----------------------------------------------------------------------------
`default_nettype none

package olia_pkg;

	// table geometry
	localparam int MAX_PATHS = 8;
	localparam int PATH_W    = 3;
	localparam int ADDR_W    = $clog2(MAX_PATHS);
	localparam int CNT_W     = $clog2(MAX_PATHS + 1);

	// field widths
	localparam int PCNT_W  = 4;
	localparam int WIN_W   = 32;
	localparam int LOSS_W  = 32;
	localparam int RTT_W   = 20;
	localparam int ALPHA_W = 16;
	localparam int MAG_W   = 15;

	// rate compare product widths
	localparam int MUL_W  = LOSS_W + RTT_W;
	localparam int HI_W   = MUL_W - LOSS_W + RTT_W;
	localparam int PROD_W = LOSS_W + HI_W;

	// stream widths
	localparam int S_TDATA_W = 120;
	localparam int M_TDATA_W = 24;

	localparam logic [PCNT_W-1:0] PATH_COUNT_RST = PCNT_W'(2);

	// command codes carried on tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// one stored path; the larger loss counter is kept
	typedef struct packed {
		logic [RTT_W-1:0]  rtt;
		logic [LOSS_W-1:0] loss;
		logic [WIN_W-1:0]  win;
	} path_entry_t;

	localparam int ENTRY_W = $bits(path_entry_t);

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_READ,
		SC_EVAL,
		SC_CMP,
		SC_DONE
	} scan_state_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_MUL,
		CS_LO,
		CS_HI,
		CS_SUM,
		CS_CMP
	} cmp_step_t;

	typedef struct packed {
		logic idle;
		logic done;
	} scan_stat_t;

	typedef struct packed {
		logic done;
		logic gt;
		logic eq;
	} cmp_res_t;

	typedef struct packed {
		logic signed [ALPHA_W-1:0] alpha;
		logic                      in_best;
		logic                      in_max_window;
	} alpha_res_t;

	// 0.5 / n in Q1.15, rounded to nearest with halves up
	function automatic logic [MAG_W-1:0] half_over(input logic [CNT_W-1:0] n);
		logic [MAG_W-1:0] mag;
		unique case (n)
			CNT_W'(1): mag = MAG_W'(16384);
			CNT_W'(2): mag = MAG_W'(8192);
			CNT_W'(3): mag = MAG_W'(5461);
			CNT_W'(4): mag = MAG_W'(4096);
			CNT_W'(5): mag = MAG_W'(3277);
			CNT_W'(6): mag = MAG_W'(2731);
			CNT_W'(7): mag = MAG_W'(2341);
			CNT_W'(8): mag = MAG_W'(2048);
			default:   mag = '0;
		endcase
		return mag;
	endfunction

endpackage

`default_nettype wire

>>> design/olia_alpha_calc.sv
// ----------------------------------------------------------------------------
// olia_alpha_calc
// OLIA alpha calculator over a table of per-path congestion statistics
// ----------------------------------------------------------------------------
// Input transactions arrive on the s_ stream; s_tuser selects write or query.
// A write stores one path's window, larger loss counter and rtt in the path
// table and produces no output. A query walks paths 0..n-1
// (n = path_count clamped to 8), reading one table entry per visit from a
// registered-read memory and comparing rates through a shared cross-multiply
// unit. A visit that skips a path or seeds the best set passes through the
// read and evaluate states; a visit whose rate is compared also waits in the
// compare state for the cross-multiply unit. The first path with loss only
// seeds, so at most n-1 visits compare.
// One query is in flight at a time; s_tready is low while it runs and rises
// again in the cycle the result is loaded into the output register.
// The result lands in an output register on the m_ stream; while it waits
// there, writes and the next query are still accepted, and a later result
// holds inside the block until the register drains.
// Reset clears the table (per-entry valid bits, so it is usable at once), the
// output valid flag, and sets path_count to 2. The user must write path_count
// via cfg_we / cfg_wdata only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module olia_alpha_calc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// path, cwnd, lost_bytes_a, lost_bytes_b, rtt_us, zero pad
	input  logic [olia_pkg::S_TDATA_W-1:0]     s_tdata,
	// cmd
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// alpha, in_best, in_max_window, zero pad
	output logic [olia_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                               cfg_we,
	input  logic [olia_pkg::PCNT_W-1:0]        cfg_wdata
);

	localparam int CWND_LSB = olia_pkg::PATH_W;
	localparam int LA_LSB   = CWND_LSB + olia_pkg::WIN_W;
	localparam int LB_LSB   = LA_LSB + olia_pkg::LOSS_W;
	localparam int RTT_LSB  = LB_LSB + olia_pkg::LOSS_W;

	logic [olia_pkg::PCNT_W-1:0]    path_count_q;
	logic [olia_pkg::MAX_PATHS-1:0] valid_q;
	logic                           rd_valid_s1;
	logic                           m_tvalid_q;
	logic [olia_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic [olia_pkg::PATH_W-1:0]    s_path;
	logic [olia_pkg::LOSS_W-1:0]    s_loss_a, s_loss_b;
	logic                           s_accept, wr_en, query, out_free, res_taken;
	logic                           rd_en;
	logic [olia_pkg::ADDR_W-1:0]    rd_addr, wr_addr;
	olia_pkg::path_entry_t          wr_entry, ram_entry, rd_entry;
	olia_pkg::scan_stat_t           stat;
	olia_pkg::alpha_res_t           res;

	// input transaction decode
	assign s_tready = stat.idle;
	assign s_accept = s_tvalid && s_tready;
	assign s_path   = s_tdata[olia_pkg::PATH_W-1:0];
	assign s_loss_a = s_tdata[LA_LSB +: olia_pkg::LOSS_W];
	assign s_loss_b = s_tdata[LB_LSB +: olia_pkg::LOSS_W];
	assign query    = s_accept && (s_tuser == olia_pkg::CMD_QUERY);
	assign wr_en    = s_accept && (s_tuser == olia_pkg::CMD_WRITE)
		&& (int'(s_path) < olia_pkg::MAX_PATHS);
	assign wr_addr  = olia_pkg::ADDR_W'(s_path);

	// stored entry keeps only the larger loss counter
	always_comb begin
		wr_entry.win  = s_tdata[CWND_LSB +: olia_pkg::WIN_W];
		wr_entry.loss = (s_loss_a > s_loss_b) ? s_loss_a : s_loss_b;
		wr_entry.rtt  = s_tdata[RTT_LSB +: olia_pkg::RTT_W];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_count_q <= olia_pkg::PATH_COUNT_RST;
		end else if (cfg_we) begin
			path_count_q <= cfg_wdata;
		end
	end

	// entry valid bits; an unwritten entry reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			if (rd_en) rd_valid_s1 <= valid_q[rd_addr];
		end
	end

	olia_ram #(
		.WIDTH (olia_pkg::ENTRY_W),
		.DEPTH (olia_pkg::MAX_PATHS)
	) u_path_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_entry)
	);

	assign rd_entry = rd_valid_s1 ? ram_entry : '0;

	olia_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (query),
		.start_path (s_path),
		.path_count (path_count_q),
		.res_taken  (res_taken),
		.entry      (rd_entry),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.stat       (stat),
		.res        (res)
	);

	// output register
	assign out_free  = !m_tvalid_q || m_tready;
	assign res_taken = stat.done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_taken) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_taken) begin
			m_tdata_q <= olia_pkg::M_TDATA_W'({res.in_max_window, res.in_best, res.alpha});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a result only appears after the scan has finished
	a_out_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(stat.done))
		else $error("output became valid without a finished query");

	// an accepted query keeps the input closed in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query |=> !s_tready)
		else $error("input ready right after a query transaction");

endmodule

`default_nettype wire

>>> design/olia_ram.sv
// ----------------------------------------------------------------------------
// olia_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module olia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/olia_rate_cmp.sv
// ----------------------------------------------------------------------------
// olia_rate_cmp
// multi-cycle exact compare of loss_a / rtt_a^2 against loss_b / rtt_b^2
// by cross-multiplication into 72-bit products
// ----------------------------------------------------------------------------
`default_nettype none

module olia_rate_cmp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [olia_pkg::LOSS_W-1:0]   a_loss,
	input  logic [olia_pkg::RTT_W-1:0]    a_rtt,
	input  logic [olia_pkg::LOSS_W-1:0]   b_loss,
	input  logic [olia_pkg::RTT_W-1:0]    b_rtt,
	output olia_pkg::cmp_res_t            res
);

	olia_pkg::cmp_step_t step_q, step_d;

	// operand registers: left side is a_loss * b_rtt^2, right side b_loss * a_rtt^2
	logic [olia_pkg::LOSS_W-1:0] lx_q, rx_q;
	logic [olia_pkg::RTT_W-1:0]  lr_q, rr_q;
	logic [olia_pkg::MUL_W-1:0]  lp_q, rp_q;
	logic [olia_pkg::MUL_W-1:0]  llo_q, rlo_q;
	logic [olia_pkg::HI_W-1:0]   lhi_q, rhi_q;
	logic [olia_pkg::PROD_W-1:0] lsum_q, rsum_q;
	logic                        done_q, gt_q, eq_q;

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= olia_pkg::CS_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// step sequence
	always_comb begin
		step_d = step_q;
		unique case (step_q)
			olia_pkg::CS_IDLE: if (start) step_d = olia_pkg::CS_MUL;
			olia_pkg::CS_MUL:  step_d = olia_pkg::CS_LO;
			olia_pkg::CS_LO:   step_d = olia_pkg::CS_HI;
			olia_pkg::CS_HI:   step_d = olia_pkg::CS_SUM;
			olia_pkg::CS_SUM:  step_d = olia_pkg::CS_CMP;
			olia_pkg::CS_CMP:  step_d = olia_pkg::CS_IDLE;
			default:           step_d = olia_pkg::CS_IDLE;
		endcase
	end

	// datapath: one multiplier per side per step
	always_ff @(posedge clk) begin
		unique case (step_q)
			olia_pkg::CS_IDLE: begin
				if (start) begin
					lx_q <= a_loss;
					lr_q <= b_rtt;
					rx_q <= b_loss;
					rr_q <= a_rtt;
				end
			end
			olia_pkg::CS_MUL: begin
				lp_q <= olia_pkg::MUL_W'(lx_q) * olia_pkg::MUL_W'(lr_q);
				rp_q <= olia_pkg::MUL_W'(rx_q) * olia_pkg::MUL_W'(rr_q);
			end
			olia_pkg::CS_LO: begin
				llo_q <= olia_pkg::MUL_W'(lp_q[olia_pkg::LOSS_W-1:0])
					* olia_pkg::MUL_W'(lr_q);
				rlo_q <= olia_pkg::MUL_W'(rp_q[olia_pkg::LOSS_W-1:0])
					* olia_pkg::MUL_W'(rr_q);
			end
			olia_pkg::CS_HI: begin
				lhi_q <= olia_pkg::HI_W'(lp_q[olia_pkg::MUL_W-1:olia_pkg::LOSS_W])
					* olia_pkg::HI_W'(lr_q);
				rhi_q <= olia_pkg::HI_W'(rp_q[olia_pkg::MUL_W-1:olia_pkg::LOSS_W])
					* olia_pkg::HI_W'(rr_q);
			end
			olia_pkg::CS_SUM: begin
				lsum_q <= olia_pkg::PROD_W'(llo_q) + {lhi_q, olia_pkg::LOSS_W'(0)};
				rsum_q <= olia_pkg::PROD_W'(rlo_q) + {rhi_q, olia_pkg::LOSS_W'(0)};
			end
			olia_pkg::CS_CMP: begin
				gt_q <= lsum_q > rsum_q;
				eq_q <= lsum_q == rsum_q;
			end
			default: begin
			end
		endcase
	end

	// completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == olia_pkg::CS_CMP);
		end
	end

	assign res.done = done_q;
	assign res.gt   = gt_q;
	assign res.eq   = eq_q;

	// greater and equal never reported together
	a_gt_eq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> !(res.gt && res.eq))
		else $error("rate compare reports greater and equal at once");

endmodule

`default_nettype wire

>>> design/olia_scan.sv
// ----------------------------------------------------------------------------
// olia_scan
// query sequencer: walks the active paths in the table, builds the
// max-window and best-rate sets, then forms alpha for the queried path
// ----------------------------------------------------------------------------
`default_nettype none

module olia_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [olia_pkg::PATH_W-1:0]     start_path,
	input  logic [olia_pkg::PCNT_W-1:0]     path_count,
	input  logic                            res_taken,
	input  olia_pkg::path_entry_t           entry,
	output logic                            rd_en,
	output logic [olia_pkg::ADDR_W-1:0]     rd_addr,
	output olia_pkg::scan_stat_t            stat,
	output olia_pkg::alpha_res_t            res
);

	olia_pkg::scan_state_t state_q, state_d;

	logic [olia_pkg::ADDR_W-1:0]    idx_q;
	logic [olia_pkg::CNT_W-1:0]     n_q, n_d;
	logic [olia_pkg::PATH_W-1:0]    qpath_q;
	logic [olia_pkg::MAX_PATHS-1:0] m_mask_q, b_mask_q, idx_bit;
	logic [olia_pkg::WIN_W-1:0]     max_win_q;
	logic                           have_best_q;
	logic [olia_pkg::LOSS_W-1:0]    best_loss_q, cand_loss_q;
	logic [olia_pkg::RTT_W-1:0]     best_rtt_q, cand_rtt_q;
	logic                           last, skip, no_loss, cmp_start;
	olia_pkg::cmp_res_t             cmp_res;

	// active path count, clamped to the table size
	always_comb begin
		if (path_count > olia_pkg::PCNT_W'(olia_pkg::MAX_PATHS)) begin
			n_d = olia_pkg::CNT_W'(olia_pkg::MAX_PATHS);
		end else begin
			n_d = olia_pkg::CNT_W'(path_count);
		end
	end

	assign last    = (olia_pkg::CNT_W'(idx_q) + olia_pkg::CNT_W'(1)) >= n_q;
	assign skip    = (entry.rtt == '0);
	assign no_loss = (entry.loss == '0);
	assign idx_bit = olia_pkg::MAX_PATHS'(1) << idx_q;
	assign rd_addr = idx_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olia_pkg::SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		cmp_start = 1'b0;
		unique case (state_q)
			olia_pkg::SC_IDLE: begin
				if (start) begin
					state_d = (n_d == '0) ? olia_pkg::SC_DONE : olia_pkg::SC_READ;
				end
			end
			olia_pkg::SC_READ: begin
				rd_en   = 1'b1;
				state_d = olia_pkg::SC_EVAL;
			end
			olia_pkg::SC_EVAL: begin
				if (!skip && !no_loss && have_best_q) begin
					cmp_start = 1'b1;
					state_d   = olia_pkg::SC_CMP;
				end else begin
					state_d = last ? olia_pkg::SC_DONE : olia_pkg::SC_READ;
				end
			end
			olia_pkg::SC_CMP: begin
				if (cmp_res.done) begin
					state_d = last ? olia_pkg::SC_DONE : olia_pkg::SC_READ;
				end
			end
			olia_pkg::SC_DONE: begin
				if (res_taken) state_d = olia_pkg::SC_IDLE;
			end
			default: state_d = olia_pkg::SC_IDLE;
		endcase
	end

	// running maxima and set masks
	always_ff @(posedge clk) begin
		unique case (state_q)
			olia_pkg::SC_IDLE: begin
				if (start) begin
					idx_q       <= '0;
					n_q         <= n_d;
					qpath_q     <= start_path;
					m_mask_q    <= '0;
					b_mask_q    <= '0;
					max_win_q   <= '0;
					have_best_q <= 1'b0;
				end
			end
			olia_pkg::SC_EVAL: begin
				cand_loss_q <= entry.loss;
				cand_rtt_q  <= entry.rtt;
				if (!skip) begin
					// window set: a new maximum restarts it, a tie with a nonzero maximum joins it
					if (entry.win > max_win_q) begin
						max_win_q <= entry.win;
						m_mask_q  <= idx_bit;
					end else if (entry.win == max_win_q && max_win_q != '0) begin
						m_mask_q <= m_mask_q | idx_bit;
					end
					// first path with loss seeds the best-rate set
					if (!no_loss && !have_best_q) begin
						have_best_q <= 1'b1;
						best_loss_q <= entry.loss;
						best_rtt_q  <= entry.rtt;
						b_mask_q    <= idx_bit;
					end
				end
				if ((skip || no_loss || !have_best_q) && !last) begin
					idx_q <= idx_q + olia_pkg::ADDR_W'(1);
				end
			end
			olia_pkg::SC_CMP: begin
				if (cmp_res.done) begin
					if (cmp_res.gt) begin
						best_loss_q <= cand_loss_q;
						best_rtt_q  <= cand_rtt_q;
						b_mask_q    <= idx_bit;
					end else if (cmp_res.eq) begin
						b_mask_q <= b_mask_q | idx_bit;
					end
					if (!last) idx_q <= idx_q + olia_pkg::ADDR_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// rate compare against the current best
	olia_rate_cmp u_rate_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmp_start),
		.a_loss (entry.loss),
		.a_rtt  (entry.rtt),
		.b_loss (best_loss_q),
		.b_rtt  (best_rtt_q),
		.res    (cmp_res)
	);

	// set sizes and alpha for the queried path
	logic [olia_pkg::MAX_PATHS-1:0] bm_mask;
	logic [olia_pkg::CNT_W-1:0]     cnt_m, cnt_bm;
	logic                           qm, qb, q_in_table;

	always_comb begin
		bm_mask = b_mask_q & ~m_mask_q;
		cnt_m   = '0;
		cnt_bm  = '0;
		for (int k = 0; k < olia_pkg::MAX_PATHS; k++) begin
			cnt_m  = cnt_m + olia_pkg::CNT_W'(m_mask_q[k]);
			cnt_bm = cnt_bm + olia_pkg::CNT_W'(bm_mask[k]);
		end
		q_in_table = int'(qpath_q) < olia_pkg::MAX_PATHS;
		qm = q_in_table && m_mask_q[olia_pkg::ADDR_W'(qpath_q)];
		qb = q_in_table && b_mask_q[olia_pkg::ADDR_W'(qpath_q)];

		res.in_best       = qb;
		res.in_max_window = qm;
		if (qb && !qm) begin
			res.alpha = $signed(olia_pkg::ALPHA_W'(olia_pkg::half_over(cnt_bm)));
		end else if (cnt_bm != '0 && qm) begin
			res.alpha = -$signed(olia_pkg::ALPHA_W'(olia_pkg::half_over(cnt_m)));
		end else begin
			res.alpha = '0;
		end
	end

	assign stat.idle = (state_q == olia_pkg::SC_IDLE);
	assign stat.done = (state_q == olia_pkg::SC_DONE);

	// compare results only arrive while waiting on them
	a_cmp_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_res.done |-> state_q == olia_pkg::SC_CMP)
		else $error("rate compare finished outside its wait state");

	// a nonzero alpha needs the path in one of the sets
	a_alpha_member: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && res.alpha != '0 |-> res.in_best || res.in_max_window)
		else $error("nonzero alpha for a path outside both sets");

	// positive alpha only for best-rate paths outside the window set
	a_alpha_pos: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && res.alpha > 0 |-> res.in_best && !res.in_max_window)
		else $error("positive alpha for a path not in best minus max");

endmodule

`default_nettype wire
